[rtl/hbbd_pkg.sv]
// ----------------------------------------------------------------------------
// hbbd_pkg
// shared types and constants of the hashed block buffer directory
// ----------------------------------------------------------------------------
package hbbd_pkg;

    localparam int OP_W         = 2;
    localparam int DEV_W        = 16;
    localparam int BLK_W        = 32;
    localparam int IDX_W        = 5;
    localparam int CNT_W        = 8;
    localparam int ST_W         = 2;
    localparam int HASH_DIGIT_W = 2;
    localparam int HASH_STEPS   = BLK_W / HASH_DIGIT_W;

    localparam logic [OP_W-1:0] OP_GET     = 2'd0;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
    localparam logic [OP_W-1:0] OP_PIN     = 2'd2;
    localparam logic [OP_W-1:0] OP_UNPIN   = 2'd3;

    localparam logic [ST_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [ST_W-1:0] STATUS_NO_FREE   = 2'd1;
    localparam logic [ST_W-1:0] STATUS_UNDERFLOW = 2'd2;
    localparam logic [ST_W-1:0] STATUS_OVERFLOW  = 2'd3;

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_HASH,
        ST_SCAN,
        ST_PICK,
        ST_EXEC
    } state_t;

    typedef struct packed
    {
        logic load;
        logic hash_step;
        logic scan_step;
        logic pick;
        logic exec;
    } cmd_t;

    typedef struct packed
    {
        logic hash_done;
        logic scan_done;
    } stat_t;

endpackage

[rtl/hbbd_ctrl.sv]
// ----------------------------------------------------------------------------
// hbbd_ctrl
// sequencer of the buffer directory: accept, hash, scan, pick, execute
// ----------------------------------------------------------------------------
module hbbd_ctrl
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [hbbd_pkg::OP_W-1:0]     operation,
    output logic                          out_valid,
    input  logic                          out_stall,
    output hbbd_pkg::cmd_t                cmd,
    input  hbbd_pkg::stat_t               stat
);
    import hbbd_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (operation == OP_GET) ? ST_HASH : ST_EXEC;
                end
            end
            ST_HASH:
            begin
                if (stat.hash_done)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (stat.scan_done)
                begin
                    state_next = ST_PICK;
                end
            end
            ST_PICK:
            begin
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            ST_HASH:
            begin
                cmd.hash_step = 1'b1;
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
            end
            ST_PICK:
            begin
                cmd.pick = 1'b1;
            end
            ST_EXEC:
            begin
                cmd.exec = out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    assign out_valid_next = cmd.exec || (out_valid_reg && out_stall);
    assign out_valid      = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[rtl/hbbd_datapath.sv]
// ----------------------------------------------------------------------------
// hbbd_datapath
// entry store, serial bucket hash, lookup scan and entry update
// ----------------------------------------------------------------------------
module hbbd_datapath
#(
    parameter int NUM_BUFFERS = 32,
    parameter int NUM_BUCKETS = 13
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  hbbd_pkg::cmd_t                 cmd,
    output hbbd_pkg::stat_t                stat,
    input  logic [hbbd_pkg::OP_W-1:0]      operation,
    input  logic [hbbd_pkg::DEV_W-1:0]     device_id,
    input  logic [hbbd_pkg::BLK_W-1:0]     block_number,
    input  logic [hbbd_pkg::IDX_W-1:0]     buffer_index,
    output logic [hbbd_pkg::IDX_W-1:0]     granted_index,
    output logic                           was_hit,
    output logic                           needs_disk_read,
    output logic [hbbd_pkg::ST_W-1:0]      status,
    output logic [hbbd_pkg::CNT_W-1:0]     count_after
);
    import hbbd_pkg::*;

    localparam int IW = $clog2(NUM_BUFFERS);
    localparam int XW = (IW > IDX_W) ? IW : IDX_W;
    localparam int BW = $clog2(NUM_BUCKETS + 1);
    localparam int HW = $clog2(HASH_STEPS);
    localparam int CW = (IW > HW) ? IW : HW;
    localparam int TW = BW + HASH_DIGIT_W;
    localparam logic [TW-1:0] M1 = TW'(NUM_BUCKETS);
    localparam logic [TW-1:0] M2 = TW'(2 * NUM_BUCKETS);
    localparam logic [TW-1:0] M3 = TW'(3 * NUM_BUCKETS);
    localparam logic [IW-1:0] LAST_RANK = IW'(NUM_BUFFERS - 1);

    // entry store
    logic [DEV_W-1:0] tag_dev_reg [NUM_BUFFERS];
    logic [BLK_W-1:0] tag_blk_reg [NUM_BUFFERS];
    logic             valid_reg   [NUM_BUFFERS];
    logic [CNT_W-1:0] count_reg   [NUM_BUFFERS];
    logic [BW-1:0]    bucket_reg  [NUM_BUFFERS];
    logic [IW-1:0]    rank_reg    [NUM_BUFFERS];

    // request
    logic [OP_W-1:0]  op_reg,       op_next;
    logic [DEV_W-1:0] dev_reg,      dev_next;
    logic [BLK_W-1:0] blk_reg,      blk_next;
    logic [IDX_W-1:0] idx_reg,      idx_next;
    logic             in_range_reg, in_range_next;
    logic [IW-1:0]    ptr_reg,      ptr_next;
    logic [BLK_W-1:0] x_reg,        x_next;
    logic [BW-1:0]    h_reg,        h_next;
    logic [CW-1:0]    cnt_reg,      cnt_next;

    // scan results
    logic             found_v_reg,  found_v_next;
    logic [IW-1:0]    found_reg,    found_next;
    logic             own_v_reg,    own_v_next;
    logic [IW-1:0]    own_reg,      own_next;
    logic [IW-1:0]    own_rank_reg, own_rank_next;
    logic             oth_v_reg,    oth_v_next;
    logic [IW-1:0]    oth_reg,      oth_next;
    logic [BW-1:0]    oth_bkt_reg,  oth_bkt_next;
    logic [IW-1:0]    oth_rank_reg, oth_rank_next;

    // result
    logic [IDX_W-1:0] granted_reg,  granted_next;
    logic             hit_reg,      hit_next;
    logic             rd_reg,       rd_next;
    logic [ST_W-1:0]  st_reg,       st_next;
    logic [CNT_W-1:0] cnt_out_reg,  cnt_out_next;

    logic [XW-1:0]           idx_x;
    logic [HASH_DIGIT_W-1:0] digit;
    logic [TW-1:0]           t;
    logic [BW-1:0]           h_step;
    logic [IW-1:0]           scan_idx;
    logic [IW-1:0]           addr;
    logic [DEV_W-1:0]        rd_dev;
    logic [BLK_W-1:0]        rd_blk;
    logic                    rd_valid;
    logic [CNT_W-1:0]        rd_count;
    logic [BW-1:0]           rd_bucket;
    logic [IW-1:0]           rd_rank;
    logic                    same_bkt;
    logic                    is_free;
    logic [IDX_W-1:0]        ptr5;

    logic                    wr_en;
    logic                    tag_we;
    logic                    mru_en;
    logic                    wr_valid;
    logic [CNT_W-1:0]        wr_count;
    logic [BW-1:0]           wr_bucket;
    logic [IDX_W-1:0]        res_granted;
    logic                    res_hit;
    logic                    res_rd;
    logic [ST_W-1:0]         res_st;
    logic [CNT_W-1:0]        res_cnt;

    assign idx_x    = XW'(buffer_index);
    assign scan_idx = cnt_reg[IW-1:0];
    assign addr     = cmd.scan_step ? scan_idx : ptr_reg;
    assign ptr5     = IDX_W'(XW'(ptr_reg));

    assign rd_dev    = tag_dev_reg[addr];
    assign rd_blk    = tag_blk_reg[addr];
    assign rd_valid  = valid_reg[addr];
    assign rd_count  = count_reg[addr];
    assign rd_bucket = bucket_reg[addr];
    assign rd_rank   = rank_reg[addr];

    assign same_bkt = (rd_bucket == h_reg);
    assign is_free  = (rd_count == '0);

    assign stat.hash_done = (cnt_reg == CW'(HASH_STEPS - 1));
    assign stat.scan_done = (cnt_reg == CW'(NUM_BUFFERS - 1));

    // two hash bits per step, remainder kept below the bucket count
    assign digit = x_reg[BLK_W-1 -: HASH_DIGIT_W];
    assign t     = {h_reg, digit};

    always_comb
    begin
        if (t >= M3)
        begin
            h_step = BW'(t - M3);
        end
        else if (t >= M2)
        begin
            h_step = BW'(t - M2);
        end
        else if (t >= M1)
        begin
            h_step = BW'(t - M1);
        end
        else
        begin
            h_step = BW'(t);
        end
    end

    always_comb
    begin
        op_next       = op_reg;
        dev_next      = dev_reg;
        blk_next      = blk_reg;
        idx_next      = idx_reg;
        in_range_next = in_range_reg;
        ptr_next      = ptr_reg;
        x_next        = x_reg;
        h_next        = h_reg;
        cnt_next      = cnt_reg;
        found_v_next  = found_v_reg;
        found_next    = found_reg;
        own_v_next    = own_v_reg;
        own_next      = own_reg;
        own_rank_next = own_rank_reg;
        oth_v_next    = oth_v_reg;
        oth_next      = oth_reg;
        oth_bkt_next  = oth_bkt_reg;
        oth_rank_next = oth_rank_reg;
        if (cmd.load)
        begin
            op_next       = operation;
            dev_next      = device_id;
            blk_next      = block_number;
            idx_next      = buffer_index;
            in_range_next = ((XW + 1)'(buffer_index) < (XW + 1)'(NUM_BUFFERS));
            ptr_next      = idx_x[IW-1:0];
            x_next        = BLK_W'(device_id) ^ block_number;
            h_next        = '0;
            cnt_next      = '0;
            found_v_next  = 1'b0;
            own_v_next    = 1'b0;
            oth_v_next    = 1'b0;
        end
        else if (cmd.hash_step)
        begin
            x_next   = x_reg << HASH_DIGIT_W;
            h_next   = h_step;
            cnt_next = stat.hash_done ? '0 : cnt_reg + 1'b1;
        end
        else if (cmd.scan_step)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (same_bkt && rd_valid && rd_dev == dev_reg && rd_blk == blk_reg
                && !found_v_reg)
            begin
                found_v_next = 1'b1;
                found_next   = scan_idx;
            end
            if (is_free && same_bkt && (!own_v_reg || rd_rank < own_rank_reg))
            begin
                own_v_next    = 1'b1;
                own_next      = scan_idx;
                own_rank_next = rd_rank;
            end
            // lowest other bucket first, then least recent within it
            if (is_free && !same_bkt && (!oth_v_reg || rd_bucket < oth_bkt_reg
                || (rd_bucket == oth_bkt_reg && rd_rank < oth_rank_reg)))
            begin
                oth_v_next    = 1'b1;
                oth_next      = scan_idx;
                oth_bkt_next  = rd_bucket;
                oth_rank_next = rd_rank;
            end
        end
        else if (cmd.pick)
        begin
            if (found_v_reg)
            begin
                ptr_next = found_reg;
            end
            else if (own_v_reg)
            begin
                ptr_next = own_reg;
            end
            else
            begin
                ptr_next = oth_reg;
            end
        end
    end

    always_comb
    begin
        wr_en       = 1'b0;
        tag_we      = 1'b0;
        mru_en      = 1'b0;
        wr_valid    = rd_valid;
        wr_count    = rd_count;
        wr_bucket   = rd_bucket;
        res_granted = idx_reg;
        res_hit     = 1'b0;
        res_rd      = 1'b0;
        res_st      = STATUS_OK;
        res_cnt     = '0;
        if (op_reg == OP_GET)
        begin
            if (found_v_reg)
            begin
                res_granted = ptr5;
                res_hit     = 1'b1;
                if (rd_count == COUNT_MAX)
                begin
                    res_st  = STATUS_OVERFLOW;
                    res_cnt = COUNT_MAX;
                end
                else
                begin
                    wr_en    = 1'b1;
                    wr_count = rd_count + 1'b1;
                    wr_valid = 1'b1;
                    res_rd   = !rd_valid;
                    res_cnt  = wr_count;
                end
            end
            else if (own_v_reg || oth_v_reg)
            begin
                wr_en       = 1'b1;
                tag_we      = 1'b1;
                wr_count    = CNT_W'(1);
                wr_valid    = 1'b1;
                wr_bucket   = h_reg;
                mru_en      = !own_v_reg;
                res_granted = ptr5;
                res_rd      = 1'b1;
                res_cnt     = CNT_W'(1);
            end
            else
            begin
                res_granted = '0;
                res_st      = STATUS_NO_FREE;
            end
        end
        else if (in_range_reg)
        begin
            if (op_reg == OP_PIN)
            begin
                if (rd_count == COUNT_MAX)
                begin
                    res_st = STATUS_OVERFLOW;
                end
                else
                begin
                    wr_en    = 1'b1;
                    wr_count = rd_count + 1'b1;
                end
            end
            else
            begin
                if (rd_count == '0)
                begin
                    res_st = STATUS_UNDERFLOW;
                end
                else
                begin
                    wr_en    = 1'b1;
                    wr_count = rd_count - 1'b1;
                    mru_en   = (op_reg == OP_RELEASE) && (rd_count == CNT_W'(1));
                end
            end
            res_cnt = wr_en ? wr_count : rd_count;
        end
        wr_en  = wr_en && cmd.exec;
        tag_we = tag_we && cmd.exec;
        mru_en = mru_en && cmd.exec;
    end

    assign granted_next = cmd.exec ? res_granted : granted_reg;
    assign hit_next     = cmd.exec ? res_hit     : hit_reg;
    assign rd_next      = cmd.exec ? res_rd      : rd_reg;
    assign st_next      = cmd.exec ? res_st      : st_reg;
    assign cnt_out_next = cmd.exec ? res_cnt     : cnt_out_reg;

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        dev_reg      <= dev_next;
        blk_reg      <= blk_next;
        idx_reg      <= idx_next;
        ptr_reg      <= ptr_next;
        x_reg        <= x_next;
        h_reg        <= h_next;
        found_reg    <= found_next;
        own_reg      <= own_next;
        own_rank_reg <= own_rank_next;
        oth_reg      <= oth_next;
        oth_bkt_reg  <= oth_bkt_next;
        oth_rank_reg <= oth_rank_next;
        granted_reg  <= granted_next;
        hit_reg      <= hit_next;
        rd_reg       <= rd_next;
        st_reg       <= st_next;
        cnt_out_reg  <= cnt_out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_range_reg <= 1'b0;
            cnt_reg      <= '0;
            found_v_reg  <= 1'b0;
            own_v_reg    <= 1'b0;
            oth_v_reg    <= 1'b0;
        end
        else
        begin
            in_range_reg <= in_range_next;
            cnt_reg      <= cnt_next;
            found_v_reg  <= found_v_next;
            own_v_reg    <= own_v_next;
            oth_v_reg    <= oth_v_next;
        end
    end

    // tags are only matched behind the valid bit
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NUM_BUFFERS; i++)
        begin
            if (tag_we && ptr_reg == IW'(i))
            begin
                tag_dev_reg[i] <= dev_reg;
                tag_blk_reg[i] <= blk_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_BUFFERS; i++)
            begin
                valid_reg[i]  <= 1'b0;
                count_reg[i]  <= '0;
                bucket_reg[i] <= BW'(i % NUM_BUCKETS);
                rank_reg[i]   <= IW'(i);
            end
        end
        else
        begin
            for (int i = 0; i < NUM_BUFFERS; i++)
            begin
                if (wr_en && ptr_reg == IW'(i))
                begin
                    valid_reg[i]  <= wr_valid;
                    count_reg[i]  <= wr_count;
                    bucket_reg[i] <= wr_bucket;
                end
                // move to most recent, close the gap above the old rank
                if (mru_en)
                begin
                    if (ptr_reg == IW'(i))
                    begin
                        rank_reg[i] <= LAST_RANK;
                    end
                    else if (rank_reg[i] > rd_rank)
                    begin
                        rank_reg[i] <= rank_reg[i] - 1'b1;
                    end
                end
            end
        end
    end

    assign granted_index   = granted_reg;
    assign was_hit         = hit_reg;
    assign needs_disk_read = rd_reg;
    assign status          = st_reg;
    assign count_after     = cnt_out_reg;

endmodule

[rtl/hashed_block_buffer_directory.sv]
// ----------------------------------------------------------------------------
// hashed_block_buffer_directory
// directory of a hashed disk block buffer cache with least recent reuse
// ----------------------------------------------------------------------------
// One request is handled at a time. A get reduces (device xor block) mod
// NUM_BUCKETS two bits at a time, then scans the directory at one entry per
// cycle, then takes a pick step and an update step. Release, pin and unpin skip
// the hash, scan and pick and go straight to the update.
// A finished result sits in the output register while the next request is
// taken; the update waits only when that register is still stalled.
// ----------------------------------------------------------------------------
module hashed_block_buffer_directory
#(
    parameter int NUM_BUFFERS = 32,
    parameter int NUM_BUCKETS = 13
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [hbbd_pkg::OP_W-1:0]      operation,
    input  logic [hbbd_pkg::DEV_W-1:0]     device_id,
    input  logic [hbbd_pkg::BLK_W-1:0]     block_number,
    input  logic [hbbd_pkg::IDX_W-1:0]     buffer_index,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [hbbd_pkg::IDX_W-1:0]     granted_index,
    output logic                           was_hit,
    output logic                           needs_disk_read,
    output logic [hbbd_pkg::ST_W-1:0]      status,
    output logic [hbbd_pkg::CNT_W-1:0]     count_after
);
    import hbbd_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    hbbd_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    hbbd_datapath
    #(
        .NUM_BUFFERS (NUM_BUFFERS),
        .NUM_BUCKETS (NUM_BUCKETS)
    )
    u_datapath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .operation       (operation),
        .device_id       (device_id),
        .block_number    (block_number),
        .buffer_index    (buffer_index),
        .granted_index   (granted_index),
        .was_hit         (was_hit),
        .needs_disk_read (needs_disk_read),
        .status          (status),
        .count_after     (count_after)
    );

endmodule

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// checks the buffer cache directory against a cycle-free directory predictor
// ----------------------------------------------------------------------------
// A directed sequence covers count underflow, unpin and release at zero, pin
// and get overflow, hits on valid entries, bucket migration and an exhausted
// cache. It is followed by random traffic over a small pool of block tags, so
// that hits and reuse are common. Both sides idle in random bursts, except
// near the end of the run. Each result transfer is compared field by field
// with the oldest predicted outcome.
// ----------------------------------------------------------------------------
module testbench;

    import hbbd_pkg::*;

    localparam int          NUM_BUFFERS = 32;
    localparam int unsigned NUM_BUCKETS = 13;
    localparam int          POOL_SIZE   = 24;
    localparam int          RANDOM_REQS = 1380;
    localparam int          QUIET_TAIL  = 200;
    localparam int          CYCLE_LIMIT = 1000000;

    typedef struct
    {
        logic [OP_W-1:0]  op;
        logic [DEV_W-1:0] dev;
        logic [BLK_W-1:0] blk;
        logic [IDX_W-1:0] idx;
        bit               drain;
    } request_t;

    typedef struct
    {
        logic [IDX_W-1:0] granted;
        logic             hit;
        logic             disk_read;
        logic [ST_W-1:0]  st;
        logic [CNT_W-1:0] cnt;
    } outcome_t;

    logic             clk             = 1'b0;
    logic             rst_n           = 1'b0;
    logic             in_valid        = 1'b0;
    logic             in_stall;
    logic [OP_W-1:0]  operation       = OP_GET;
    logic [DEV_W-1:0] device_id       = '0;
    logic [BLK_W-1:0] block_number    = '0;
    logic [IDX_W-1:0] buffer_index    = '0;
    logic             out_valid;
    logic             out_stall       = 1'b0;
    logic [IDX_W-1:0] granted_index;
    logic             was_hit;
    logic             needs_disk_read;
    logic [ST_W-1:0]  status;
    logic [CNT_W-1:0] count_after;

    // shadow directory
    logic [31:0]      dir_dev    [NUM_BUFFERS];
    logic [BLK_W-1:0] dir_blk    [NUM_BUFFERS];
    bit               dir_valid  [NUM_BUFFERS];
    logic [CNT_W-1:0] dir_count  [NUM_BUFFERS];
    int               dir_bucket [NUM_BUFFERS];
    int               dir_rank   [NUM_BUFFERS];

    request_t request_q[$];
    outcome_t outcome_q[$];
    request_t presented;
    outcome_t want;
    int       total_requests = 0;
    int       requests_sent  = 0;
    int       results_seen   = 0;
    int       mismatch_count = 0;
    int       send_hold_off  = 0;
    int       recv_hold_off  = 0;
    int       cycle_count    = 0;

    hashed_block_buffer_directory DUT
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .operation       (operation),
        .device_id       (device_id),
        .block_number    (block_number),
        .buffer_index    (buffer_index),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .granted_index   (granted_index),
        .was_hit         (was_hit),
        .needs_disk_read (needs_disk_read),
        .status          (status),
        .count_after     (count_after)
    );

    function automatic void make_most_recent(int e);
        int r;
        r = dir_rank[e];
        for (int i = 0; i < NUM_BUFFERS; i++)
        begin
            if (dir_rank[i] > r)
                dir_rank[i]--;
        end
        dir_rank[e] = NUM_BUFFERS - 1;
    endfunction

    function automatic int least_recent_free(int bucket);
        int best;
        best = -1;
        for (int i = 0; i < NUM_BUFFERS; i++)
        begin
            if (dir_bucket[i] == bucket && dir_count[i] == 0)
            begin
                if (best < 0 || dir_rank[i] < dir_rank[best])
                    best = i;
            end
        end
        return best;
    endfunction

    function automatic outcome_t cache_access(request_t r);
        outcome_t o;
        int       h;
        int       hit_e;
        int       e;
        bit       moved;
        o.granted   = r.idx;
        o.hit       = 1'b0;
        o.disk_read = 1'b0;
        o.st        = STATUS_OK;
        o.cnt       = '0;
        hit_e       = -1;
        moved       = 1'b0;
        if (r.op == OP_GET)
        begin
            h = int'(({16'b0, r.dev} ^ r.blk) % NUM_BUCKETS);
            for (int i = 0; i < NUM_BUFFERS; i++)
            begin
                if (hit_e < 0 && dir_bucket[i] == h && dir_dev[i] == {16'b0, r.dev}
                    && dir_blk[i] == r.blk)
                    hit_e = i;
            end
            if (hit_e >= 0)
            begin
                o.granted = IDX_W'(hit_e);
                o.hit     = 1'b1;
                if (dir_count[hit_e] == COUNT_MAX)
                    o.st = STATUS_OVERFLOW;
                else
                begin
                    dir_count[hit_e]++;
                    o.disk_read      = !dir_valid[hit_e];
                    dir_valid[hit_e] = 1'b1;
                end
                o.cnt = dir_count[hit_e];
            end
            else
            begin
                e = least_recent_free(h);
                for (int b = 0; b < NUM_BUCKETS && e < 0; b++)
                begin
                    if (b != h)
                    begin
                        e     = least_recent_free(b);
                        moved = (e >= 0);
                    end
                end
                if (e < 0)
                begin
                    o.granted = '0;
                    o.st      = STATUS_NO_FREE;
                end
                else
                begin
                    dir_dev[e]    = {16'b0, r.dev};
                    dir_blk[e]    = r.blk;
                    dir_count[e]  = CNT_W'(1);
                    dir_valid[e]  = 1'b1;
                    dir_bucket[e] = h;
                    if (moved)
                        make_most_recent(e);
                    o.granted   = IDX_W'(e);
                    o.disk_read = 1'b1;
                    o.cnt       = CNT_W'(1);
                end
            end
        end
        else
        begin
            e = int'(r.idx);
            if (r.op == OP_PIN)
            begin
                if (dir_count[e] == COUNT_MAX)
                    o.st = STATUS_OVERFLOW;
                else
                    dir_count[e]++;
            end
            else if (dir_count[e] == 0)
                o.st = STATUS_UNDERFLOW;
            else
            begin
                dir_count[e]--;
                if (r.op == OP_RELEASE && dir_count[e] == 0)
                    make_most_recent(e);
            end
            o.cnt = dir_count[e];
        end
        return o;
    endfunction

    task automatic queue_request(logic [OP_W-1:0] op, logic [DEV_W-1:0] dev,
                                 logic [BLK_W-1:0] blk, logic [IDX_W-1:0] idx, bit drain);
        request_t r;
        r.op    = op;
        r.dev   = dev;
        r.blk   = blk;
        r.idx   = idx;
        r.drain = drain;
        request_q.push_back(r);
    endtask

    task automatic report_mismatch(string what, int got, int exp_val);
        $display("mismatch on %s at result %0d: got %0d, want %0d",
                 what, results_seen, got, exp_val);
        mismatch_count++;
    endtask

    initial
    begin
        forever #4 clk = ~clk;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid      <= 1'b0;
            send_hold_off = 0;
            for (int i = 0; i < NUM_BUFFERS; i++)
            begin
                dir_dev[i]    = '1;
                dir_blk[i]    = '0;
                dir_valid[i]  = 1'b0;
                dir_count[i]  = '0;
                dir_bucket[i] = int'(i % NUM_BUCKETS);
                dir_rank[i]   = i;
            end
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                outcome_q.push_back(cache_access(presented));
                requests_sent++;
            end
            if (!in_valid || !in_stall)
            begin
                if (send_hold_off > 0)
                begin
                    send_hold_off--;
                    in_valid <= 1'b0;
                end
                else if (request_q.size() == 0)
                    in_valid <= 1'b0;
                else if (request_q[0].drain && outcome_q.size() != 0)
                    in_valid <= 1'b0;
                else
                begin
                    presented    = request_q.pop_front();
                    operation    <= presented.op;
                    device_id    <= presented.dev;
                    block_number <= presented.blk;
                    buffer_index <= presented.idx;
                    in_valid     <= 1'b1;
                    if (requests_sent < total_requests - QUIET_TAIL
                        && $urandom_range(0, 9) == 0)
                        send_hold_off = $urandom_range(1, 14);
                end
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall     <= 1'b0;
            recv_hold_off = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (outcome_q.size() == 0)
                    report_mismatch("unexpected transfer", int'(granted_index), 0);
                else
                begin
                    want = outcome_q.pop_front();
                    if (granted_index !== want.granted)
                        report_mismatch("granted_index", int'(granted_index),
                                        int'(want.granted));
                    if (was_hit !== want.hit)
                        report_mismatch("was_hit", int'(was_hit), int'(want.hit));
                    if (needs_disk_read !== want.disk_read)
                        report_mismatch("needs_disk_read", int'(needs_disk_read),
                                        int'(want.disk_read));
                    if (status !== want.st)
                        report_mismatch("status", int'(status), int'(want.st));
                    if (count_after !== want.cnt)
                        report_mismatch("count_after", int'(count_after), int'(want.cnt));
                end
                results_seen++;
            end
            if (recv_hold_off > 0)
            begin
                recv_hold_off--;
                out_stall <= 1'b1;
            end
            else if (results_seen < total_requests - QUIET_TAIL
                     && $urandom_range(0, 11) == 0)
            begin
                recv_hold_off = $urandom_range(1, 14) - 1;
                out_stall     <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    initial
    begin
        logic [DEV_W-1:0] pool_dev [POOL_SIZE];
        logic [BLK_W-1:0] pool_blk [POOL_SIZE];
        logic [OP_W-1:0]  op;
        logic [DEV_W-1:0] dev;
        logic [BLK_W-1:0] blk;
        int               pick;
        int               k;

        // underflow, unpin without promotion, release to zero
        queue_request(OP_RELEASE, 16'hFFFF, 32'hFFFFFFFF, 5'd5, 1'b0);
        queue_request(OP_UNPIN, 16'd0, 32'd0, 5'd31, 1'b0);
        queue_request(OP_PIN, 16'd0, 32'd0, 5'd7, 1'b0);
        queue_request(OP_UNPIN, 16'd0, 32'd0, 5'd7, 1'b0);
        queue_request(OP_PIN, 16'd0, 32'd0, 5'd7, 1'b0);
        queue_request(OP_RELEASE, 16'd0, 32'd0, 5'd7, 1'b0);

        // count saturation on the bucket 3 entry, by get and by pin
        for (k = 0; k < 256; k++)
            queue_request(OP_GET, 16'd0, 32'd3, 5'd0, 1'b0);
        queue_request(OP_PIN, 16'd0, 32'd0, 5'd3, 1'b0);
        for (k = 0; k < 255; k++)
            queue_request(OP_RELEASE, 16'd0, 32'd0, 5'd3, 1'b0);

        // miss then hit on a valid entry, field extremes
        queue_request(OP_GET, 16'd0, 32'd0, 5'd0, 1'b0);
        queue_request(OP_GET, 16'd0, 32'd0, 5'd0, 1'b0);
        queue_request(OP_GET, 16'hFFFF, 32'hFFFFFFFF, 5'd31, 1'b0);
        queue_request(OP_GET, 16'hFFFF, 32'hFFFFFFFF, 5'd31, 1'b0);

        // exhaust the cache, then free every entry
        for (k = 0; k < 34; k++)
            queue_request(OP_GET, 16'd1, BLK_W'(k), 5'd0, k == 0);
        for (k = 0; k < 64; k++)
            queue_request(OP_RELEASE, 16'd0, 32'd0, IDX_W'(k % NUM_BUFFERS), 1'b0);

        for (k = 0; k < POOL_SIZE; k++)
        begin
            pool_dev[k] = (k < 4) ? DEV_W'($urandom_range(0, 3)) : DEV_W'($urandom);
            pool_blk[k] = (k < 4) ? BLK_W'($urandom_range(0, 40)) : $urandom;
        end

        for (k = 0; k < RANDOM_REQS; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                op = OP_GET;
            else if (pick < 75)
                op = OP_RELEASE;
            else if (pick < 85)
                op = OP_PIN;
            else
                op = OP_UNPIN;
            if (op == OP_GET && $urandom_range(0, 6) != 0)
            begin
                pick = $urandom_range(0, POOL_SIZE - 1);
                dev  = pool_dev[pick];
                blk  = pool_blk[pick];
            end
            else
            begin
                dev = DEV_W'($urandom);
                blk = $urandom;
            end
            queue_request(op, dev, blk, IDX_W'($urandom_range(0, NUM_BUFFERS - 1)),
                          k == 0 || $urandom_range(0, 299) == 0);
        end

        total_requests = request_q.size();

        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (requests_sent < total_requests)
            @(posedge clk);
        while (outcome_q.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);

        if (mismatch_count == 0 && outcome_q.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
